### rtl/pps_pkg.sv
// Package for the preemptive priority scheduler: words, codes and the scan carry.
package pps_pkg;

  localparam int unsigned MaxTasksDefault = 16;
  localparam logic [15:0] TimeMax         = 16'hFFFF;

  localparam logic [1:0] ModeLoad  = 2'd0;
  localparam logic [1:0] ModeTick  = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  task_priority;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
  } in_word_t;

  typedef struct packed {
    logic        ran;
    logic [3:0]  task_slot;
    logic [15:0] first_run_time;
    logic        finished;
    logic [15:0] completion_time;
    logic        all_done;
    logic [15:0] tick_time;
  } out_word_t;

  // Best candidate so far plus a saturating count of slots with work left.
  typedef struct packed {
    logic        found;
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic        started;
    logic [15:0] first_run;
    logic [1:0]  busy_cnt;
  } carry_t;

  // Control strobes broadcast from the sequencer to every slot.
  typedef struct packed {
    logic load;
    logic clear;
    logic update;
  } cell_ctrl_t;

  function automatic logic [15:0] sat_inc(logic [15:0] t);
    return (t == TimeMax) ? TimeMax : t + 16'd1;
  endfunction

endpackage

### rtl/pps_cell.sv
// One task slot of the scheduler chain: holds the task and merges it into the passing carry.
module pps_cell
  import pps_pkg::*;
#(
  parameter int unsigned Idx   = 0,
  parameter int unsigned SlotW = 4,
  parameter int unsigned CntW  = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  in_word_t         load_word_i,
  input  logic [CntW-1:0]  count_i,
  input  logic [15:0]      time_i,
  input  logic [SlotW-1:0] upd_slot_i,
  input  carry_t           carry_i,
  input  logic [SlotW-1:0] slot_i,
  output carry_t           carry_o,
  output logic [SlotW-1:0] slot_o
);

  logic [7:0]       prio_q;
  logic [15:0]      arrival_q;
  logic [15:0]      remaining_q;
  logic [15:0]      first_run_q;
  logic             started_q;
  carry_t           carry_d, carry_q;
  logic [SlotW-1:0] slot_d, slot_q;
  logic             loaded, eligible, take, has_work, is_upd;

  assign loaded   = count_i > CntW'(Idx);
  assign has_work = loaded && (remaining_q != 16'd0);
  assign eligible = has_work && (arrival_q <= time_i);
  assign take     = eligible && (!carry_i.found || (prio_q > carry_i.prio) ||
                    ((prio_q == carry_i.prio) && (arrival_q < carry_i.arrival)));
  assign is_upd   = ctrl_i.update && (upd_slot_i == SlotW'(Idx));

  always_comb begin
    carry_d       = carry_i;
    slot_d        = slot_i;
    carry_d.found = carry_i.found | eligible;
    if (take) begin
      carry_d.prio      = prio_q;
      carry_d.arrival   = arrival_q;
      carry_d.remaining = remaining_q;
      carry_d.started   = started_q;
      carry_d.first_run = first_run_q;
      slot_d            = SlotW'(Idx);
    end
    // saturate at two: only zero, one or more matters
    if (has_work && carry_i.busy_cnt != 2'd2) begin
      carry_d.busy_cnt = carry_i.busy_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      started_q <= 1'b0;
    end else if (ctrl_i.load && count_i == CntW'(Idx)) begin
      started_q <= 1'b0;
    end else if (is_upd) begin
      started_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    slot_q  <= slot_d;
    if (ctrl_i.load && count_i == CntW'(Idx)) begin
      prio_q      <= load_word_i.task_priority;
      arrival_q   <= load_word_i.arrival_time;
      remaining_q <= load_word_i.burst_length;
      first_run_q <= 16'd0;
    end else if (is_upd) begin
      remaining_q <= remaining_q - 16'd1;
      if (!started_q) begin
        first_run_q <= time_i;
      end
    end
  end

  assign carry_o = carry_q;
  assign slot_o  = slot_q;

endmodule

### rtl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: sequencer, time, slot chain, result register.
//
// Input channel (in_valid_i, in_stall_o, in_word_i) takes one word per command:
// load stores a task in the next free slot, clear empties the table and zeroes
// time, tick runs one scheduling step. Load and clear finish in the accept
// cycle and give no result; mode 3 is dropped. A load into a full table is
// dropped too.
// A tick scans the chain of MAX_TASKS slot cells, one cell per cycle, each cell
// folding its task into the best candidate handed on by its neighbor. The
// winner is updated and the result word written as the sequencer leaves the done
// state that follows the scan state, and the input stalls until then; the chain
// length sets how long the scan state lasts.
// Output channel (out_valid_o, out_stall_i, out_word_o) carries one word per
// tick. The result register holds while the receiver stalls; the next command
// is taken meanwhile, but a following tick waits to post its result until the
// register is free.
// Reset empties the table, clears the started flags and sets time to zero;
// task fields need no clearing since only loaded slots are read.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MaxTasksDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned SlotW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] scan_q;
  logic [CntW-1:0] count_q;
  logic [15:0]     time_q;
  logic            out_valid_q;
  out_word_t       out_word_q;

  logic            in_acc, finish, done_now;
  cell_ctrl_t      ctrl;
  carry_t          chain [MAX_TASKS+1];
  logic [SlotW-1:0] slots [MAX_TASKS+1];
  carry_t          best;
  logic [31:0]     slot_ext;
  out_word_t       res;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign finish     = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  assign best     = chain[MAX_TASKS];
  assign ctrl.load   = in_acc && (in_word_i.mode == ModeLoad);
  assign ctrl.clear  = in_acc && (in_word_i.mode == ModeClear);
  assign ctrl.update = finish && best.found;

  assign chain[0] = '0;
  assign slots[0] = '0;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    pps_cell #(
      .Idx  (k),
      .SlotW(SlotW),
      .CntW (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .load_word_i(in_word_i),
      .count_i    (count_q),
      .time_i     (time_q),
      .upd_slot_i (slots[MAX_TASKS]),
      .carry_i    (chain[k]),
      .slot_i     (slots[k]),
      .carry_o    (chain[k+1]),
      .slot_o     (slots[k+1])
    );
  end

  // the winner still holds its work, so it is the only busy slot when the count is one
  assign done_now = (best.busy_cnt == 2'd0) ||
                    ((best.busy_cnt == 2'd1) && best.found && (best.remaining == 16'd1));
  assign slot_ext = 32'(slots[MAX_TASKS]);

  always_comb begin
    res                 = '0;
    res.ran             = best.found;
    res.all_done        = done_now;
    res.tick_time       = time_q;
    if (best.found) begin
      res.task_slot      = slot_ext[3:0];
      res.first_run_time = best.started ? best.first_run : time_q;
      res.finished       = (best.remaining == 16'd1);
      if (best.remaining == 16'd1) begin
        res.completion_time = sat_inc(time_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_q      <= '0;
      count_q     <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a finishing tick refills the register in the same cycle
      if (out_valid_q && !out_stall_i && !finish) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (ctrl.load && count_q < CntW'(MAX_TASKS)) begin
            count_q <= count_q + CntW'(1);
          end
          if (ctrl.clear) begin
            count_q <= '0;
            time_q  <= '0;
          end
          if (in_acc && in_word_i.mode == ModeTick) begin
            scan_q  <= '0;
            state_q <= StScan;
          end
        end
        StScan: begin
          // advance until the wave has left the last cell
          scan_q <= scan_q + CntW'(1);
          if (scan_q == CntW'(MAX_TASKS - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (finish) begin
            out_valid_q <= 1'b1;
            time_q      <= sat_inc(time_q);
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_TASKS))
    else $error("task count beyond table depth");

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.ran && out_word_o.all_done) |-> out_word_o.finished)
    else $error("all done reported while the running task has work left");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.ran) |-> (!out_word_o.finished &&
      out_word_o.completion_time == 16'd0))
    else $error("idle tick reports a completion");

  a_time_fixed_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |=> $stable(time_q))
    else $error("time moved during a scan");

endmodule

### bench/tb_top.sv
// Self-checking bench for the preemptive priority scheduler: directed rows and random mixes.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  localparam int unsigned Slots       = MaxTasksDefault;
  localparam logic [1:0]  ModeSpare   = 2'd3;
  localparam int unsigned RandomItems = 1250;
  localparam int unsigned DrainCycles = 4 * (Slots + 2);

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t report;
  } plan_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  preemptive_priority_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  // Scheduler state as the bench expects it.
  logic [7:0]  sched_prio    [Slots];
  logic [15:0] sched_arr     [Slots];
  logic [15:0] sched_left    [Slots];
  logic [15:0] sched_first   [Slots];
  bit          sched_started [Slots];
  int unsigned sched_count;
  logic [15:0] sched_now;

  out_word_t   due_reports[$];
  plan_row_t   plan[$];
  int unsigned mismatches;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic in_word_t cmd(logic [1:0] m, logic [7:0] p, logic [15:0] a, logic [15:0] b);
    in_word_t w;
    w.mode          = m;
    w.task_priority = p;
    w.arrival_time  = a;
    w.burst_length  = b;
    return w;
  endfunction

  function automatic out_word_t idle_report(bit done, logic [15:0] t);
    out_word_t rep;
    rep          = '0;
    rep.all_done = done;
    rep.tick_time = t;
    return rep;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_word_t random_load(bit tied);
    in_word_t    w;
    int unsigned r;
    int unsigned at;
    w.mode          = ModeLoad;
    w.task_priority = tied ? 8'($urandom_range(0, 2)) : 8'($urandom);
    at = 32'(sched_now) + (tied ? $urandom_range(0, 2) : $urandom_range(0, 12));
    r = $urandom_range(0, 99);
    if (r < 8) w.arrival_time = 16'($urandom);
    else w.arrival_time = (at > 32'hFFFF) ? TimeMax : 16'(at);
    r = $urandom_range(0, 99);
    if (r < 5) w.burst_length = 16'd0;
    else if (r < 9) w.burst_length = 16'($urandom);
    else w.burst_length = 16'($urandom_range(1, 6));
    return w;
  endfunction

  // Update the expected table for one accepted word; a tick yields a report.
  task automatic advance_model(input in_word_t w, output bit has_report, output out_word_t rep);
    bit          found;
    bit          all_idle;
    int unsigned best;
    logic [15:0] next_now;
    has_report = 1'b0;
    rep        = '0;
    found      = 1'b0;
    best       = 0;
    all_idle   = 1'b1;
    next_now   = (sched_now == TimeMax) ? TimeMax : sched_now + 16'd1;
    case (w.mode)
      ModeLoad: begin
        if (sched_count < Slots) begin
          sched_prio[sched_count]    = w.task_priority;
          sched_arr[sched_count]     = w.arrival_time;
          sched_left[sched_count]    = w.burst_length;
          sched_started[sched_count] = 1'b0;
          sched_first[sched_count]   = 16'd0;
          sched_count++;
        end
      end
      ModeClear: begin
        sched_count = 0;
        sched_now   = 16'd0;
        foreach (sched_started[i]) sched_started[i] = 1'b0;
      end
      ModeTick: begin
        for (int i = 0; i < int'(sched_count); i++) begin
          if (sched_arr[i] <= sched_now && sched_left[i] != 16'd0) begin
            // Higher priority wins, then earlier arrival; a later slot never wins a full tie.
            if (!found || sched_prio[i] > sched_prio[best] ||
                (sched_prio[i] == sched_prio[best] && sched_arr[i] < sched_arr[best])) begin
              best  = i;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          if (!sched_started[best]) begin
            sched_started[best] = 1'b1;
            sched_first[best]   = sched_now;
          end
          sched_left[best]   = sched_left[best] - 16'd1;
          rep.ran            = 1'b1;
          rep.task_slot      = 4'(best);
          rep.first_run_time = sched_first[best];
          if (sched_left[best] == 16'd0) begin
            rep.finished        = 1'b1;
            rep.completion_time = next_now;
          end
        end
        for (int i = 0; i < int'(sched_count); i++) begin
          if (sched_left[i] != 16'd0) all_idle = 1'b0;
        end
        rep.all_done  = all_idle;
        rep.tick_time = sched_now;
        sched_now     = next_now;
        has_report    = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Offer one word after a random gap and hold it until taken; entered at a falling edge.
  task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                           input out_word_t typed_rep = '0);
    int        gap;
    bit        has_report;
    out_word_t rep;
    gap = quiet ? 0 : pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    advance_model(w, has_report, rep);
    if (has_report) due_reports = {due_reports, (typed ? typed_rep : rep)};
    @(negedge clk_i);
  endtask

  task automatic add_row(input in_word_t w, input bit typed = 1'b0,
                         input out_word_t rep = '0);
    plan_row_t row;
    row.word   = w;
    row.typed  = typed;
    row.report = rep;
    plan = {plan, row};
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        $error("report word with none pending: %h", out_word);
        mismatches++;
      end else begin
        out_word_t want;
        want = due_reports.pop_front();
        check_field("ran", 16'(want.ran), 16'(out_word.ran));
        check_field("task_slot", 16'(want.task_slot), 16'(out_word.task_slot));
        check_field("first_run_time", want.first_run_time, out_word.first_run_time);
        check_field("finished", 16'(want.finished), 16'(out_word.finished));
        check_field("completion_time", want.completion_time, out_word.completion_time);
        check_field("all_done", 16'(want.all_done), 16'(out_word.all_done));
        check_field("tick_time", want.tick_time, out_word.tick_time);
      end
    end
  end

  initial begin : receiver
    int stall_left;
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 30) begin
        out_stall  <= 1'b1;
        stall_left = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2) : $urandom_range(14, 59);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #60ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned n_loads;
    int unsigned n_ticks;
    int unsigned work;
    int unsigned r;
    bit          tied;
    in_word_t    w;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    quiet       = 1'b0;
    mismatches  = 0;
    sched_count = 0;
    sched_now   = 16'd0;
    sent        = 0;
    foreach (sched_started[i]) sched_started[i] = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_row(cmd(ModeTick, 8'd0, 16'd0, 16'd0), 1'b1, idle_report(1'b1, 16'd0));
    add_row(cmd(ModeSpare, 8'hFF, 16'hFFFF, 16'hFFFF));
    add_row(cmd(ModeLoad, 8'hFF, 16'd0, 16'd1));
    add_row(cmd(ModeTick, 8'd0, 16'd0, 16'd0));
    // Zero burst: stored but never runs.
    add_row(cmd(ModeLoad, 8'd200, 16'd0, 16'd0));
    add_row(cmd(ModeTick, 8'd0, 16'd0, 16'd0), 1'b1, idle_report(1'b1, 16'd2));
    add_row(cmd(ModeClear, 8'd0, 16'd0, 16'd0));
    add_row(cmd(ModeTick, 8'd0, 16'd0, 16'd0), 1'b1, idle_report(1'b1, 16'd0));
    // Equal priorities: earlier arrival first, then lower slot; slot 3 wins over slot 0 at tick 4.
    add_row(cmd(ModeLoad, 8'd7, 16'd2, 16'd2));
    add_row(cmd(ModeLoad, 8'd7, 16'd1, 16'd2));
    add_row(cmd(ModeLoad, 8'd7, 16'd1, 16'd1));
    add_row(cmd(ModeLoad, 8'd9, 16'd4, 16'd1));
    add_row(cmd(ModeLoad, 8'd0, 16'hFFFF, 16'hFFFF));
    repeat (6) add_row(cmd(ModeTick, 8'd0, 16'd0, 16'd0));
    add_row(cmd(ModeTick, 8'd0, 16'd0, 16'd0), 1'b1, idle_report(1'b0, 16'd7));
    add_row(cmd(ModeTick, 8'd0, 16'd0, 16'd0));
    add_row(cmd(ModeClear, 8'd0, 16'd0, 16'd0));
    foreach (plan[k]) send_word(plan[k].word, plan[k].typed, plan[k].report);

    while (sent < RandomItems) begin
      quiet = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 3) != 0) begin
        send_word(cmd(ModeClear, 8'($urandom), 16'($urandom), 16'($urandom)));
        sent++;
      end
      tied    = ($urandom_range(0, 2) == 0);
      n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 6);
      work    = 0;
      for (int k = 0; k < int'(n_loads); k++) begin
        w = random_load(tied);
        if (w.burst_length < 16'd16) work += w.burst_length;
        if (sched_count < Slots) sent++;
        send_word(w);
      end
      n_ticks = work + $urandom_range(0, 14);
      if (n_ticks > 60) n_ticks = 60;
      for (int k = 0; k < int'(n_ticks); k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_word(cmd(ModeSpare, 8'($urandom), 16'($urandom), 16'($urandom)));
        end else if (r < 10) begin
          w = random_load(tied);
          if (sched_count < Slots) sent++;
          send_word(w);
        end
        send_word(cmd(ModeTick, 8'($urandom), 16'($urandom), 16'($urandom)));
        sent++;
      end
    end

    in_valid <= 1'b0;
    quiet = 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
